/* rtl/msl_pkg.sv */
// Shared constants, register indexes and divider types for the margin loss block.
package msl_pkg;

  localparam int MAX_CLASSES_DEF = 32;
  localparam int SCORE_BITS_DEF  = 16;

  localparam int LEN_W      = 6;
  localparam int MODE_W     = 2;
  localparam int ENTRY_W    = 7;
  localparam int ROW_LOSS_W = 22;
  localparam int MASK_W     = 32;
  localparam int TOTAL_W    = 40;
  localparam int FRAME_W    = 16;
  localparam int ACC_W      = 28;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam int ONE_Q8 = 256;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REDUCE_MODE = 2'd1;

  localparam logic [MODE_W-1:0] MODE_MEAN = 2'd1;

  localparam logic signed [ENTRY_W-1:0] ENTRY_END = -7'sd1;

  localparam int DIV_DVD_W = TOTAL_W;
  localparam int DIV_DVS_W = FRAME_W;

  typedef struct packed {
    logic                 start;
    logic [DIV_DVD_W-1:0] dividend;
    logic [DIV_DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* rtl/msl_if.sv */
// Handshake interfaces for the element, result and configuration channels.
interface msl_in_if #(parameter int SCORE_BITS = msl_pkg::SCORE_BITS_DEF);
  logic                                 valid;
  logic                                 ready;
  logic signed [SCORE_BITS-1:0]         score;
  logic signed [msl_pkg::ENTRY_W-1:0]   target_entry;
  logic                                 last_row;
  modport source (output valid, output score, output target_entry, output last_row,
                  input ready);
  modport sink (input valid, input score, input target_entry, input last_row,
                output ready);
endinterface

interface msl_out_if;
  logic                              valid;
  logic                              ready;
  logic [msl_pkg::ROW_LOSS_W-1:0]    row_loss;
  logic [msl_pkg::MASK_W-1:0]        target_mask;
  logic [msl_pkg::TOTAL_W-1:0]       batch_total;
  logic                              total_valid;
  logic                              target_error;
  modport source (output valid, output row_loss, output target_mask, output batch_total,
                  output total_valid, output target_error, input ready);
  modport sink (input valid, input row_loss, input target_mask, input batch_total,
                input total_valid, input target_error, output ready);
endinterface

interface msl_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [msl_pkg::CFG_IDX_W-1:0]     index;
  logic [msl_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/msl_cell.sv */
// One element cell: holds a class score and a target entry; scores rotate through the ring.
module msl_cell #(
  parameter int SCORE_BITS = msl_pkg::SCORE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                load,
  input  logic signed [SCORE_BITS-1:0]        load_score,
  input  logic signed [msl_pkg::ENTRY_W-1:0]  load_entry,
  input  logic                                shift,
  input  logic signed [SCORE_BITS-1:0]        next_score,
  output logic signed [SCORE_BITS-1:0]        score_q,
  output logic signed [msl_pkg::ENTRY_W-1:0]  entry_q
);
  import msl_pkg::*;

  logic signed [SCORE_BITS-1:0] score_r;
  logic signed [ENTRY_W-1:0]    entry_r;

  always_ff @(posedge clk) begin
    if (load) begin
      score_r <= load_score;
      entry_r <= load_entry;
    end else if (shift) begin
      score_r <= next_score;
    end
  end

  assign score_q = score_r;
  assign entry_q = entry_r;

endmodule

/* rtl/msl_div.sv */
// Restoring divider, one quotient bit per cycle.
module msl_div (
  input  logic              clk,
  input  logic              rst_n,
  input  msl_pkg::div_req_t req,
  output msl_pkg::div_rsp_t rsp
);
  import msl_pkg::*;

  localparam int CNT_W = $clog2(DIV_DVD_W + 1);

  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_DVS_W:0]   rem_r;
  logic [DIV_DVD_W-1:0] quo_r;
  logic [DIV_DVS_W-1:0] dvs_r;
  logic [DIV_DVS_W:0]   rem_sh;
  logic                 fits;

  always_comb begin
    rem_sh = {rem_r[DIV_DVS_W-1:0], quo_r[DIV_DVD_W-1]};
    fits   = rem_sh >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_DVD_W);
        rem_r  <= '0;
        quo_r  <= req.dividend;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= fits ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
        quo_r <= {quo_r[DIV_DVD_W-2:0], fits};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

/* rtl/multilabel_margin_loss_unit.sv */
// Top level of the multilabel margin loss block: element ring, hinge walker and divider.
//
// Usage: each input item on in_ch carries one element of a row (score, target
// entry, last_row). Items are taken one per cycle while in_ch.ready is high,
// until the active row length (row_length, clamped to 1..MAX_CLASSES) have
// arrived. The row is then scored: each listed target is selected and then the
// score ring rotates a full revolution past the hinge adder; a target entry at
// or above the row length is skipped. The row sum then goes through a
// bit-serial divider; in mean mode the last row of a batch adds a second pass
// that divides the batch total by the row count. One result item per row appears
// on out_ch and is held until taken; elements of the next row are taken
// meanwhile, but the item that would close that row waits while the previous
// result is still pending. cfg_ch writes are always taken. Reset (rst_n low,
// synchronous) empties the row and the batch sums and restores row_length 32
// and mean mode.
module multilabel_margin_loss_unit #(
  parameter int MAX_CLASSES = msl_pkg::MAX_CLASSES_DEF,
  parameter int SCORE_BITS  = msl_pkg::SCORE_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  msl_in_if.sink   in_ch,
  msl_out_if.source out_ch,
  msl_cfg_if.sink  cfg_ch
);
  import msl_pkg::*;

  localparam int IDX_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int Z_W   = SCORE_BITS + 2;
  localparam int SUM_W = ((ACC_W > Z_W) ? ACC_W : Z_W) + 1;
  localparam logic [ACC_W-1:0]      ACC_MAX   = '1;
  localparam logic [ROW_LOSS_W-1:0] ROW_MAX   = '1;
  localparam logic [TOTAL_W-1:0]    TOTAL_MAX = '1;
  localparam logic [FRAME_W-1:0]    FRAME_MAX = '1;

  typedef enum logic [2:0] {S_LOAD, S_START, S_TSEL, S_PASS, S_DIVROW, S_DIVTOT} state_t;

  state_t                       state_r;
  logic [LEN_W-1:0]             row_len_r;
  logic [MODE_W-1:0]            mode_r;
  logic [LEN_W-1:0]             count_r;
  logic                         ended_r;
  logic [MAX_CLASSES-1:0]       mask_r;
  logic                         last_r;
  logic                         err_r;
  logic [LEN_W-1:0]             t_r;
  logic [IDX_W-1:0]             d_r;
  logic signed [SCORE_BITS-1:0] st_r;
  logic [ACC_W-1:0]             acc_r;
  logic [TOTAL_W-1:0]           bacc_r;
  logic [FRAME_W-1:0]           fc_r;
  div_req_t                     div_req_r;
  div_rsp_t                     div_rsp;

  logic                    out_valid_r;
  logic [ROW_LOSS_W-1:0]   out_row_loss_r;
  logic [MASK_W-1:0]       out_mask_r;
  logic [TOTAL_W-1:0]      out_total_r;
  logic                    out_tvalid_r;
  logic                    out_err_r;

  logic signed [SCORE_BITS-1:0] score_q [MAX_CLASSES];
  logic signed [ENTRY_W-1:0]    entry_q [MAX_CLASSES];

  logic [LEN_W-1:0]       len;
  logic [IDX_W-1:0]       pos;
  logic                   closing;
  logic                   in_accept;
  logic [MAX_CLASSES-1:0] mask_nxt;
  logic                   ended_nxt;
  logic                   err_comb;
  logic signed [ENTRY_W-1:0] tsel_entry;
  logic signed [Z_W-1:0]  z;
  logic [SUM_W-1:0]       acc_sum;
  logic [ACC_W-1:0]       acc_nxt;
  logic                   hinge_en;
  logic [ROW_LOSS_W-1:0]  row_loss;
  logic [TOTAL_W:0]       bsum;
  logic [TOTAL_W-1:0]     bacc_nxt;
  logic [FRAME_W-1:0]     fc_nxt;
  logic [MASK_W-1:0]      mask_out;

  // Score ring: cell i takes its neighbor's score while the walker rotates it.
  for (genvar i = 0; i < MAX_CLASSES; i++) begin : g_cell
    localparam int NXT = (i + 1) % MAX_CLASSES;
    msl_cell #(.SCORE_BITS(SCORE_BITS)) u_cell (
      .clk        (clk),
      .load       (in_accept && (pos == IDX_W'(i))),
      .load_score (in_ch.score),
      .load_entry (in_ch.target_entry),
      .shift      (state_r == S_PASS),
      .next_score (score_q[NXT]),
      .score_q    (score_q[i]),
      .entry_q    (entry_q[i])
    );
  end

  msl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  always_comb begin
    if (row_len_r == '0) begin
      len = LEN_W'(1);
    end else if ({1'b0, row_len_r} > (LEN_W+1)'(MAX_CLASSES)) begin
      len = LEN_W'(MAX_CLASSES);
    end else begin
      len = row_len_r;
    end
    if ({1'b0, count_r} >= (LEN_W+1)'(MAX_CLASSES)) begin
      pos = IDX_W'(MAX_CLASSES - 1);
    end else begin
      pos = IDX_W'(count_r);
    end
    closing   = ({1'b0, count_r} + (LEN_W+1)'(1)) >= {1'b0, len};
    in_accept = in_ch.valid && in_ch.ready;

    mask_nxt  = mask_r;
    ended_nxt = ended_r;
    if (!ended_r) begin
      if (in_ch.target_entry[ENTRY_W-1]) begin
        ended_nxt = 1'b1;
      end else if (in_ch.target_entry < $signed({1'b0, len})) begin
        for (int i = 0; i < MAX_CLASSES; i++) begin
          if (in_ch.target_entry == ENTRY_W'(i)) mask_nxt[i] = 1'b1;
        end
      end
    end

    err_comb = 1'b0;
    for (int i = 0; i < MAX_CLASSES; i++) begin
      if ((LEN_W+1)'(i) < {1'b0, len}) begin
        if ((entry_q[i] < ENTRY_END) ||
            (!entry_q[i][ENTRY_W-1] && (entry_q[i] >= $signed({1'b0, len})))) begin
          err_comb = 1'b1;
        end
      end
    end

    tsel_entry = entry_q[t_r[IDX_W-1:0]];

    // Hinge term for the class now at the head of the ring.
    z        = $signed(Z_W'(ONE_Q8)) - Z_W'(st_r) + Z_W'(score_q[0]);
    hinge_en = ((LEN_W+1)'(d_r) < {1'b0, len}) && !mask_r[d_r] &&
               !z[Z_W-1] && (z != '0);
    acc_sum  = SUM_W'(acc_r) + SUM_W'($unsigned(z));
    if (!hinge_en) begin
      acc_nxt = acc_r;
    end else if (acc_sum > SUM_W'(ACC_MAX)) begin
      acc_nxt = ACC_MAX;
    end else begin
      acc_nxt = acc_sum[ACC_W-1:0];
    end

    if (div_rsp.quotient > DIV_DVD_W'(ROW_MAX)) begin
      row_loss = ROW_MAX;
    end else begin
      row_loss = div_rsp.quotient[ROW_LOSS_W-1:0];
    end
    bsum     = {1'b0, bacc_r} + (TOTAL_W+1)'(row_loss);
    bacc_nxt = bsum[TOTAL_W] ? TOTAL_MAX : bsum[TOTAL_W-1:0];
    fc_nxt   = (fc_r == FRAME_MAX) ? fc_r : fc_r + FRAME_W'(1);

    mask_out = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (i < MAX_CLASSES) mask_out[i] = mask_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_len_r <= LEN_W'(32);
      mode_r    <= MODE_MEAN;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_ROW_LENGTH:  row_len_r <= cfg_ch.data[LEN_W-1:0];
        REG_REDUCE_MODE: mode_r    <= cfg_ch.data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_LOAD;
      count_r         <= '0;
      ended_r         <= 1'b0;
      mask_r          <= '0;
      bacc_r          <= '0;
      fc_r            <= '0;
      out_valid_r     <= 1'b0;
      div_req_r.start <= 1'b0;
    end else begin
      div_req_r.start <= 1'b0;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_LOAD: begin
          if (in_accept) begin
            mask_r  <= mask_nxt;
            ended_r <= ended_nxt;
            if (closing) begin
              count_r <= '0;
              last_r  <= in_ch.last_row;
              state_r <= S_START;
            end else begin
              count_r <= count_r + LEN_W'(1);
            end
          end
        end
        S_START: begin
          err_r   <= err_comb;
          acc_r   <= '0;
          t_r     <= '0;
          state_r <= S_TSEL;
        end
        S_TSEL: begin
          if ((t_r >= len) || tsel_entry[ENTRY_W-1]) begin
            div_req_r.start    <= 1'b1;
            div_req_r.dividend <= DIV_DVD_W'(acc_r);
            div_req_r.divisor  <= DIV_DVS_W'(len);
            state_r            <= S_DIVROW;
          end else if (tsel_entry >= $signed({1'b0, len})) begin
            t_r <= t_r + LEN_W'(1);
          end else begin
            st_r    <= score_q[tsel_entry[IDX_W-1:0]];
            d_r     <= '0;
            state_r <= S_PASS;
          end
        end
        S_PASS: begin
          acc_r <= acc_nxt;
          // A full revolution brings the ring back into index order.
          if (d_r == IDX_W'(MAX_CLASSES - 1)) begin
            t_r     <= t_r + LEN_W'(1);
            state_r <= S_TSEL;
          end else begin
            d_r <= d_r + IDX_W'(1);
          end
        end
        S_DIVROW: begin
          if (div_rsp.done) begin
            out_row_loss_r <= row_loss;
            out_mask_r     <= mask_out;
            out_tvalid_r   <= last_r;
            out_err_r      <= err_r;
            mask_r         <= '0;
            ended_r        <= 1'b0;
            if (last_r && (mode_r == MODE_MEAN)) begin
              bacc_r             <= bacc_nxt;
              fc_r               <= fc_nxt;
              div_req_r.start    <= 1'b1;
              div_req_r.dividend <= bacc_nxt;
              div_req_r.divisor  <= fc_nxt;
              state_r            <= S_DIVTOT;
            end else begin
              out_total_r <= last_r ? bacc_nxt : '0;
              out_valid_r <= 1'b1;
              bacc_r      <= last_r ? '0 : bacc_nxt;
              fc_r        <= last_r ? '0 : fc_nxt;
              state_r     <= S_LOAD;
            end
          end
        end
        S_DIVTOT: begin
          if (div_rsp.done) begin
            out_total_r <= div_rsp.quotient;
            out_valid_r <= 1'b1;
            bacc_r      <= '0;
            fc_r        <= '0;
            state_r     <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign in_ch.ready         = (state_r == S_LOAD) && !(closing && out_valid_r);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.row_loss     = out_row_loss_r;
  assign out_ch.target_mask  = out_mask_r;
  assign out_ch.batch_total  = out_total_r;
  assign out_ch.total_valid  = out_tvalid_r;
  assign out_ch.target_error = out_err_r;

endmodule

/* rtl/msl_checker.sv */
// Port-level checks for the margin loss block, bound to the top level.
module msl_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [msl_pkg::ROW_LOSS_W-1:0] out_row_loss,
  input logic [msl_pkg::TOTAL_W-1:0]    out_batch_total,
  input logic                           out_total_valid
);
  import msl_pkg::*;

  // A pending result holds still until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_loss) &&
                                $stable(out_batch_total))
    else $error("result changed while stalled");

  // Only the batch's last row carries a total.
  a_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_total_valid |-> out_batch_total == '0)
    else $error("batch total set on a row that is not the last");

  // Each result comes only after a row is loaded, scored and divided, so results never come back to back.
  a_no_b2b: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("second result right after the first was taken");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind multilabel_margin_loss_unit msl_checker u_msl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_row_loss    (out_ch.row_loss),
  .out_batch_total (out_ch.batch_total),
  .out_total_valid (out_ch.total_valid)
);

/* bench/multilabel_margin_loss_unit_test.sv */
// Self-checking testbench for the multilabel margin loss unit.
`timescale 1ns / 100ps

module multilabel_margin_loss_unit_test;
  import msl_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SUM   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int  CYCLE_LIMIT = 4000000;
  localparam int  N_PHASES = 12;

  typedef struct {
    logic signed [SCORE_BITS_DEF-1:0] score;
    logic signed [ENTRY_W-1:0]        entry;
    logic                             last;
  } element_t;

  typedef struct {
    logic [ROW_LOSS_W-1:0] row_loss;
    logic [MASK_W-1:0]     mask;
    logic [TOTAL_W-1:0]    total;
    logic                  total_valid;
    logic                  err;
  } row_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  msl_in_if #(.SCORE_BITS(SCORE_BITS_DEF)) in_ch ();
  msl_out_if out_ch ();
  msl_cfg_if cfg_ch ();

  multilabel_margin_loss_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #2 clk = ~clk;

  element_t    element_queue[$];
  row_result_t row_result_q[$];
  element_t    cur_elem;
  bit          in_taken;
  bit          quiet;
  int          mismatches;
  int          cycles;

  // Predictor state.
  logic [LEN_W-1:0]                 len_reg;
  logic [MODE_W-1:0]                mode_reg;
  logic signed [SCORE_BITS_DEF-1:0] row_scores[MAX_CLASSES_DEF];
  logic signed [ENTRY_W-1:0]        row_entries[MAX_CLASSES_DEF];
  logic [MASK_W-1:0]                mark;
  int                               fill;
  bit                               ended;
  longint                           batch_sum;
  int                               rows_seen;

  function automatic int active_len();
    if (len_reg < 1) return 1;
    if (len_reg > MAX_CLASSES_DEF) return MAX_CLASSES_DEF;
    return int'(len_reg);
  endfunction

  function automatic void absorb_element(element_t e);
    int len, pos, ent, st;
    longint acc, z, rl, tot;
    bit err, stop;
    row_result_t r;
    len = active_len();
    pos = (fill > MAX_CLASSES_DEF - 1) ? MAX_CLASSES_DEF - 1 : fill;
    ent = int'(e.entry);
    row_scores[pos] = e.score;
    row_entries[pos] = e.entry;
    if (!ended) begin
      if (ent < 0) ended = 1;
      else if (ent < len) mark[ent] = 1'b1;
    end
    if (pos + 1 < len) begin
      fill = pos + 1;
      return;
    end
    err = 0;
    for (int t = 0; t < len; t++) begin
      ent = int'(row_entries[t]);
      if (ent < -1 || ent >= len) err = 1;
    end
    acc = 0;
    stop = 0;
    for (int t = 0; t < len; t++) begin
      ent = int'(row_entries[t]);
      if (ent < 0) stop = 1;
      if (!stop && ent < len) begin
        st = int'(row_scores[ent]);
        for (int d = 0; d < len; d++) begin
          if (!mark[d]) begin
            z = longint'(ONE_Q8) - st + int'(row_scores[d]);
            if (z > 0) begin
              acc += z;
              if (acc > 64'hFFF_FFFF) acc = 64'hFFF_FFFF;
            end
          end
        end
      end
    end
    rl = acc / len;
    if (rl > 64'h3F_FFFF) rl = 64'h3F_FFFF;
    batch_sum += rl;
    if (batch_sum > 64'hFF_FFFF_FFFF) batch_sum = 64'hFF_FFFF_FFFF;
    if (rows_seen < 65535) rows_seen++;
    tot = 0;
    if (e.last) tot = (mode_reg == MODE_MEAN) ? batch_sum / rows_seen : batch_sum;
    r.row_loss = rl[ROW_LOSS_W-1:0];
    r.mask = mark;
    r.total = tot[TOTAL_W-1:0];
    r.total_valid = e.last;
    r.err = err;
    row_result_q.push_back(r);
    if (e.last) begin
      batch_sum = 0;
      rows_seen = 0;
    end
    fill = 0;
    mark = '0;
    ended = 0;
  endfunction

  // Element driver.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_taken = 0;
    end else if (!in_ch.valid || in_taken) begin
      in_taken = 0;
      if (element_queue.size() > 0 && (quiet || $urandom_range(0, 99) >= 24)) begin
        cur_elem = element_queue.pop_front();
        in_ch.score <= cur_elem.score;
        in_ch.target_entry <= cur_elem.entry;
        in_ch.last_row <= cur_elem.last;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= rst_n && (quiet || $urandom_range(0, 99) >= 24);
  end

  // Monitor: predicts on each accepted element, checks each accepted result.
  always @(posedge clk) begin
    row_result_t x;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      absorb_element(cur_elem);
      in_taken = 1;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (row_result_q.size() == 0) begin
        $error("result item with nothing expected");
        mismatches++;
      end else begin
        x = row_result_q.pop_front();
        if (out_ch.row_loss !== x.row_loss) begin
          $error("row_loss: expected %0d, got %0d", x.row_loss, out_ch.row_loss);
          mismatches++;
        end
        if (out_ch.target_mask !== x.mask) begin
          $error("target_mask: expected %h, got %h", x.mask, out_ch.target_mask);
          mismatches++;
        end
        if (out_ch.batch_total !== x.total) begin
          $error("batch_total: expected %0d, got %0d", x.total, out_ch.batch_total);
          mismatches++;
        end
        if (out_ch.total_valid !== x.total_valid) begin
          $error("total_valid: expected %0d, got %0d", x.total_valid, out_ch.total_valid);
          mismatches++;
        end
        if (out_ch.target_error !== x.err) begin
          $error("target_error: expected %0d, got %0d", x.err, out_ch.target_error);
          mismatches++;
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    cfg_ch.valid <= 1'b1;
    #1;
    while (!cfg_ch.ready) begin
      @(negedge clk);
      #1;
    end
    @(posedge clk);
    if (idx == REG_ROW_LENGTH) len_reg = val[LEN_W-1:0];
    else if (idx == REG_REDUCE_MODE) mode_reg = val[MODE_W-1:0];
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic push_elem(input int sc, input int ent, input bit last);
    element_t e;
    e.score = sc[SCORE_BITS_DEF-1:0];
    e.entry = ent[ENTRY_W-1:0];
    e.last = last;
    element_queue.push_back(e);
  endtask

  // One row: mostly a well-formed target list followed by an end marker and junk.
  task automatic make_row(input int len, input bit last);
    int k, sc, ent;
    bit noise;
    noise = ($urandom_range(0, 9) == 0);
    k = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len) :
        $urandom_range(0, (len < 4) ? len : 4);
    for (int i = 0; i < len; i++) begin
      sc = ($urandom_range(0, 1) == 0) ? int'($urandom) : $urandom_range(0, 1024) - 512;
      if (noise || i > k) ent = $urandom_range(0, 127) - 64;
      else if (i == k) ent = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 62) - 64 : -1;
      else if ($urandom_range(0, 9) == 0) ent = $urandom_range(len, 63);
      else ent = $urandom_range(0, len - 1);
      push_elem(sc, ent, (i == len - 1) ? last : bit'($urandom_range(0, 1)));
    end
  endtask

  task automatic settle();
    wait (element_queue.size() == 0 && !in_ch.valid && row_result_q.size() == 0);
    repeat (50) @(posedge clk);
  endtask

  int lens[N_PHASES]  = '{3, 1, 8, 0, 5, 2, 63, 4, 16, 7, 32, 6};
  logic [MODE_W-1:0] modes[N_PHASES] = '{MODE_NONE, MODE_MEAN, MODE_SUM, MODE_SPARE,
                                         MODE_MEAN, MODE_SUM, MODE_NONE, MODE_MEAN,
                                         MODE_SPARE, MODE_SUM, MODE_MEAN, MODE_NONE};

  initial begin
    int len, budget;
    in_ch.valid = 1'b0;
    in_ch.score = '0;
    in_ch.target_entry = '0;
    in_ch.last_row = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_ROW_LENGTH;
    cfg_ch.data = '0;
    len_reg = 6'd32;
    mode_reg = MODE_MEAN;
    mark = '0;
    fill = 0;
    ended = 0;
    batch_sum = 0;
    rows_seen = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Single-class rows: extreme scores and extreme entries.
    write_reg(REG_ROW_LENGTH, 8'd1);
    write_reg(REG_REDUCE_MODE, CFG_DATA_W'(MODE_SUM));
    push_elem(32767, 0, 0);
    push_elem(-32768, -1, 0);
    push_elem(0, -64, 0);
    push_elem(100, 63, 0);
    push_elem(-5, 1, 1);
    settle();
    // Duplicate target, then an out-of-range entry and an end marker below -1.
    write_reg(REG_ROW_LENGTH, 8'd4);
    write_reg(REG_REDUCE_MODE, CFG_DATA_W'(MODE_MEAN));
    push_elem(-32768, 0, 0);
    push_elem(32767, 0, 0);
    push_elem(0, 3, 0);
    push_elem(255, -1, 0);
    push_elem(-256, 1, 0);
    push_elem(512, 63, 0);
    push_elem(-32768, 2, 0);
    push_elem(32767, -2, 1);
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(REG_ROW_LENGTH, lens[p][CFG_DATA_W-1:0]);
      write_reg(REG_REDUCE_MODE, CFG_DATA_W'(modes[p]));
      quiet = (p == 5);
      len = active_len();
      budget = (len >= 32) ? 4 * len : 150;
      for (int n = 0; n < budget; n += len)
        make_row(len, $urandom_range(0, 3) == 0);
      settle();
    end
    quiet = 0;

    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
